@@ hw/rtl/bof_pkg.sv @@
// Package for the box overlap filter: command and status structs and fixed constants.
// Used by bof_ctrl, bof_dp and box_overlap_filter; depends on nothing.
package bof_pkg;

    // Fewest kept intersections that are emitted as boxes instead of one "none" result.
    localparam int unsigned MIN_KEPT = 2;

    // Width of the area threshold register and of the APB bus.
    localparam int unsigned THRESH_W = 24;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 3;

    // Width at which the area and the threshold are compared.
    localparam int unsigned AREA_CMP_W = 32;

    // Register word index of the area threshold.
    localparam logic [ADDR_W-3:0] REG_AREA_THRESHOLD = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // register the intersection of an accepted request
        logic mul;      // register the intersection area
        logic commit;   // keep the intersection if it qualifies
        logic rd;       // read the kept entry at the drain index
        logic next;     // advance the drain index
        logic clear;    // end of set: clear count, overflow flag and drain index
        logic none;     // the shown result is the "none" result
    } bof_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_ge_min;  // at least MIN_KEPT intersections kept
        logic rd_last;       // the drain index points at the last kept entry
    } bof_status_t;

endpackage

@@ hw/rtl/bof_ctrl.sv @@
// Controller state machine of the box overlap filter.
// Depends on bof_pkg for the command and status structs.
module bof_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_set_end,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 out_last,
    output bof_pkg::bof_cmd_t    cmd,
    input  bof_pkg::bof_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMMIT,
        ST_CHECK,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t state_reg;
    logic   set_end_reg;
    logic   out_valid_reg;
    logic   last_reg;
    logic   none_reg;
    logic   accept;
    logic   out_taken;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_taken = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_last  = last_reg;

    // Commands decoded from the current state.
    always_comb
    begin
        cmd         = '0;
        cmd.none    = none_reg;
        cmd.capture = accept;
        case (state_reg)
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.rd = status.count_ge_min;
            end
            ST_FETCH:
            begin
                cmd.rd = 1'b1;
            end
            ST_SHOW:
            begin
                cmd.clear = out_taken && last_reg;
                cmd.next  = out_taken && !last_reg;
            end
            default:
            begin
                cmd.mul = 1'b0;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            none_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        set_end_reg <= in_set_end;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    state_reg <= set_end_reg ? ST_CHECK : ST_IDLE;
                end
                ST_CHECK:
                begin
                    // Emit the kept boxes, or a single "none" result.
                    out_valid_reg <= 1'b1;
                    if (status.count_ge_min)
                    begin
                        none_reg <= 1'b0;
                        last_reg <= status.rd_last;
                    end
                    else
                    begin
                        none_reg <= 1'b1;
                        last_reg <= 1'b1;
                    end
                    state_reg <= ST_SHOW;
                end
                ST_FETCH:
                begin
                    out_valid_reg <= 1'b1;
                    last_reg      <= status.rd_last;
                    state_reg     <= ST_SHOW;
                end
                ST_SHOW:
                begin
                    if (out_taken)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= last_reg ? ST_IDLE : ST_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/bof_dp.sv @@
// Datapath of the box overlap filter: intersection, area, kept-box buffer and drain read.
// Depends on bof_pkg for the command and status structs and constants.
module bof_dp
#(
    parameter int unsigned BUFFER_DEPTH = 32,
    parameter int unsigned COORD_BITS   = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [COORD_BITS-1:0]         ref_x1,
    input  logic [COORD_BITS-1:0]         ref_y1,
    input  logic [COORD_BITS-1:0]         ref_x2,
    input  logic [COORD_BITS-1:0]         ref_y2,
    input  logic [COORD_BITS-1:0]         cand_x1,
    input  logic [COORD_BITS-1:0]         cand_y1,
    input  logic [COORD_BITS-1:0]         cand_x2,
    input  logic [COORD_BITS-1:0]         cand_y2,
    input  logic [bof_pkg::THRESH_W-1:0]  area_threshold,
    input  bof_pkg::bof_cmd_t             cmd,
    output bof_pkg::bof_status_t          status,
    output logic [COORD_BITS-1:0]         out_x1,
    output logic [COORD_BITS-1:0]         out_y1,
    output logic [COORD_BITS-1:0]         out_x2,
    output logic [COORD_BITS-1:0]         out_y2,
    output logic                          dropped
);

    localparam int unsigned IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned AREA_W = 2 * COORD_BITS;
    localparam int unsigned BOX_W  = 4 * COORD_BITS;

    logic [BOX_W-1:0]      kept_mem [BUFFER_DEPTH];
    logic [BOX_W-1:0]      rd_data_reg;
    logic [BOX_W-1:0]      isect_reg;
    logic                  nonempty_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [AREA_W-1:0]     area_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  overflow_reg;
    logic [IDX_W-1:0]      rd_idx_reg;

    logic [COORD_BITS-1:0] ix1;
    logic [COORD_BITS-1:0] iy1;
    logic [COORD_BITS-1:0] ix2;
    logic [COORD_BITS-1:0] iy2;
    logic                  qualifies;
    logic                  has_room;

    // Intersection of the reference and candidate boxes.
    assign ix1 = (ref_x1 > cand_x1) ? ref_x1 : cand_x1;
    assign iy1 = (ref_y1 > cand_y1) ? ref_y1 : cand_y1;
    assign ix2 = (ref_x2 < cand_x2) ? ref_x2 : cand_x2;
    assign iy2 = (ref_y2 < cand_y2) ? ref_y2 : cand_y2;

    // Capture the intersection and its side lengths, then its area.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            isect_reg    <= {ix1, iy1, ix2, iy2};
            nonempty_reg <= (ix2 > ix1) && (iy2 > iy1);
            dx_reg       <= ix2 - ix1;
            dy_reg       <= iy2 - iy1;
        end
        if (cmd.mul)
        begin
            area_reg <= AREA_W'(dx_reg) * AREA_W'(dy_reg);
        end
    end

    assign qualifies = nonempty_reg &&
                       (bof_pkg::AREA_CMP_W'(area_reg) >
                        bof_pkg::AREA_CMP_W'(area_threshold));
    assign has_room  = (count_reg < CNT_W'(BUFFER_DEPTH));

    // Kept-box buffer: appended on commit, read one entry at a time while draining.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && qualifies && has_room)
        begin
            kept_mem[count_reg[IDX_W-1:0]] <= isect_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= kept_mem[rd_idx_reg];
        end
    end

    // Fill count, overflow flag and drain index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.commit && qualifies)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.next)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
    end

    assign status.count_ge_min = (count_reg >= CNT_W'(bof_pkg::MIN_KEPT));
    assign status.rd_last      = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    // Result fields; the "none" result carries zero coordinates.
    assign out_x1  = cmd.none ? '0 : rd_data_reg[4*COORD_BITS-1:3*COORD_BITS];
    assign out_y1  = cmd.none ? '0 : rd_data_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign out_x2  = cmd.none ? '0 : rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign out_y2  = cmd.none ? '0 : rd_data_reg[COORD_BITS-1:0];
    assign dropped = overflow_reg;

endmodule

@@ hw/rtl/box_overlap_filter.sv @@
// Top level of the box overlap filter: APB register, controller and datapath.
// Depends on bof_pkg, bof_ctrl and bof_dp.

// Each request carries one candidate box and the reference box; the block keeps the
// intersection when it is non-empty, its area exceeds area_threshold and the buffer has
// room; a qualifying intersection that finds the buffer full sets dropped. A candidate
// passes through accept, area multiply and buffer update, using the single multiplier
// and the single write port of the kept-box buffer; no new request is accepted until
// its buffer update is done. On the request marked set_end a decision step follows that
// also reads the first kept entry, then the first result is shown; every further result
// is read from the buffer and then shown, and the output may be stalled. No requests
// are accepted while a set is being emitted. The buffer needs no clearing after reset.
module box_overlap_filter
#(
    parameter int unsigned BUFFER_DEPTH = 32,
    parameter int unsigned COORD_BITS   = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bof_pkg::ADDR_W-1:0]   paddr,
    input  logic [bof_pkg::DATA_W-1:0]   pwdata,
    output logic [bof_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // Candidate requests
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [COORD_BITS-1:0]        ref_x1,
    input  logic [COORD_BITS-1:0]        ref_y1,
    input  logic [COORD_BITS-1:0]        ref_x2,
    input  logic [COORD_BITS-1:0]        ref_y2,
    input  logic [COORD_BITS-1:0]        cand_x1,
    input  logic [COORD_BITS-1:0]        cand_y1,
    input  logic [COORD_BITS-1:0]        cand_x2,
    input  logic [COORD_BITS-1:0]        cand_y2,
    input  logic                         set_end,
    // Results
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS-1:0]        out_x1,
    output logic [COORD_BITS-1:0]        out_y1,
    output logic [COORD_BITS-1:0]        out_x2,
    output logic [COORD_BITS-1:0]        out_y2,
    output logic                         run_last,
    output logic                         none_found,
    output logic                         dropped
);

    logic [bof_pkg::THRESH_W-1:0] area_threshold_reg;
    logic                         reg_sel;
    bof_pkg::bof_cmd_t            cmd;
    bof_pkg::bof_status_t         status;

    // Register file: one threshold register at word 0.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[bof_pkg::ADDR_W-1:2] == bof_pkg::REG_AREA_THRESHOLD);
    assign prdata  = reg_sel ? bof_pkg::DATA_W'(area_threshold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_threshold_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            area_threshold_reg <= pwdata[bof_pkg::THRESH_W-1:0];
        end
    end

    // Sequencing of candidates and of the result drain.
    bof_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_set_end (set_end),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_last   (run_last),
        .cmd        (cmd),
        .status     (status)
    );

    // Intersection, area test and kept-box buffer.
    bof_dp
    #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .COORD_BITS   (COORD_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ref_x1         (ref_x1),
        .ref_y1         (ref_y1),
        .ref_x2         (ref_x2),
        .ref_y2         (ref_y2),
        .cand_x1        (cand_x1),
        .cand_y1        (cand_y1),
        .cand_x2        (cand_x2),
        .cand_y2        (cand_y2),
        .area_threshold (area_threshold_reg),
        .cmd            (cmd),
        .status         (status),
        .out_x1         (out_x1),
        .out_y1         (out_y1),
        .out_x2         (out_x2),
        .out_y2         (out_y2),
        .dropped        (dropped)
    );

    assign none_found = cmd.none;

endmodule
